// ----- rtl/spmq_pkg.sv -----
// ----------------------------------------------------------------------------
// spmq_pkg
// types, codes and default sizes shared by the shared pool multi queue
// ----------------------------------------------------------------------------
package spmq_pkg;

	// default sizes
	localparam int POOL_CELLS_DEF  = 1024;
	localparam int QUEUE_COUNT_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 32;

	// field widths fixed by the transaction format
	localparam int OP_W    = 2;
	localparam int QID_W   = 4;
	localparam int WORD_W  = 32;
	localparam int ERR_W   = 2;
	localparam int QID_SPAN = 2 ** QID_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_INSPECT = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [QID_W-1:0]  queue_id;
		logic [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] front_value;
		logic [WORD_W-1:0] back_value;
		logic              is_empty;
		logic [ERR_W-1:0]  error;
	} rsp_t;

endpackage

// ----- rtl/shared_pool_multi_queue.sv -----
// ----------------------------------------------------------------------------
// shared_pool_multi_queue
// several fifo queues kept as linked lists in one shared pool of cells
// ----------------------------------------------------------------------------
//
// channel   | dir | handshake           | payload
// ----------+-----+---------------------+-------------------------------------
// request   | in  | req_valid/req_stall | req_data  (operation, queue_id, value)
// response  | out | rsp_valid/rsp_stall | rsp_data  (front, back, empty, error)
//
// each transaction: the accept cycle reads the link memory,
// the next cycle updates pointers and writes the link memory back
// a new request is taken the cycle after that, not while one is in flight
// the response sits in an output register; a stalled response only holds the
// update cycle once the following request has been taken
// reset needs no clearing pass: untouched cells are handed out by a fill count
//
module shared_pool_multi_queue #(
	parameter int POOL_CELLS  = spmq_pkg::POOL_CELLS_DEF,
	parameter int QUEUE_COUNT = spmq_pkg::QUEUE_COUNT_DEF,
	parameter int DATA_WIDTH  = spmq_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  spmq_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output spmq_pkg::rsp_t rsp_data
);

	// pointer holds a cell index or the null value POOL_CELLS
	localparam int PTR_W  = $clog2(POOL_CELLS + 1);
	localparam int IDX_W  = $clog2(POOL_CELLS);
	localparam int LINK_W = PTR_W + DATA_WIDTH;
	// only ids reachable through queue_id need storage
	localparam int QT   = (QUEUE_COUNT < spmq_pkg::QID_SPAN) ? QUEUE_COUNT
		: spmq_pkg::QID_SPAN;
	localparam int QI_W = (QT > 1) ? $clog2(QT) : 1;
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_CELLS);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	// link memory: each entry holds the next cell and the data of that next cell,
	// so a pop gets the new front value from the same read
	logic [LINK_W-1:0] link_mem [POOL_CELLS];
	logic [LINK_W-1:0] rd_q;

	// per queue pointers and cached end values
	logic [PTR_W-1:0]      head_q  [QT];
	logic [PTR_W-1:0]      tail_q  [QT];
	logic [DATA_WIDTH-1:0] front_q [QT];
	logic [DATA_WIDTH-1:0] back_q  [QT];
	logic [QT-1:0]         nonempty_q;

	// free list: explicit list of returned cells, then untouched cells from fresh_q
	logic [PTR_W-1:0] free_head_q;
	logic [PTR_W-1:0] fresh_q;

	spmq_pkg::req_t req_s1;
	spmq_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	// ------------------------------------------------------------------------
	// accept side: read address comes from the incoming request
	// ------------------------------------------------------------------------
	logic             accept;
	logic             in_q_ok;
	logic [QI_W-1:0]  in_qi;
	logic             rd_en;
	logic [PTR_W-1:0] rd_ptr_addr;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign in_q_ok   = (32'(req_data.queue_id) < QUEUE_COUNT);
	assign in_qi     = in_q_ok ? req_data.queue_id[QI_W-1:0] : '0;

	always_comb begin
		rd_en       = 1'b0;
		rd_ptr_addr = free_head_q;
		case (req_data.operation)
			spmq_pkg::OP_PUSH: begin
				rd_ptr_addr = free_head_q;
				rd_en       = accept && in_q_ok && (free_head_q != NULL_PTR);
			end
			spmq_pkg::OP_POP: begin
				rd_ptr_addr = head_q[in_qi];
				// a single cell queue needs no link
				rd_en = accept && in_q_ok && nonempty_q[in_qi]
					&& (head_q[in_qi] != tail_q[in_qi]);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// update cycle
	// ------------------------------------------------------------------------
	logic                  q_ok_s1;
	logic [QI_W-1:0]       qi_s1;
	logic [63:0]           val_wide;
	logic [DATA_WIDTH-1:0] val_s1;
	logic [PTR_W-1:0]      rd_ptr;
	logic [DATA_WIDTH-1:0] rd_dat;
	logic                  ne_cur;
	logic [PTR_W-1:0]      h_cur;
	logic [PTR_W-1:0]      t_cur;
	logic                  pool_dry;
	logic [PTR_W-1:0]      new_cell;

	logic                  ne_d;
	logic [PTR_W-1:0]      head_d;
	logic [PTR_W-1:0]      tail_d;
	logic [DATA_WIDTH-1:0] front_d;
	logic [DATA_WIDTH-1:0] back_d;
	logic [PTR_W-1:0]      free_head_d;
	logic [PTR_W-1:0]      fresh_d;
	logic                  wr_en;
	logic [PTR_W-1:0]      wr_ptr_addr;
	logic [LINK_W-1:0]     wr_entry;
	logic [spmq_pkg::ERR_W-1:0] err_d;
	spmq_pkg::rsp_t        rsp_d;
	logic                  out_blocked;
	logic                  exec_fire;

	assign q_ok_s1  = (32'(req_s1.queue_id) < QUEUE_COUNT);
	assign qi_s1    = q_ok_s1 ? req_s1.queue_id[QI_W-1:0] : '0;
	assign val_wide = {32'd0, req_s1.value};
	assign val_s1   = val_wide[DATA_WIDTH-1:0];
	assign rd_ptr   = rd_q[LINK_W-1 -: PTR_W];
	assign rd_dat   = rd_q[DATA_WIDTH-1:0];
	assign ne_cur   = q_ok_s1 && nonempty_q[qi_s1];
	assign h_cur    = head_q[qi_s1];
	assign t_cur    = tail_q[qi_s1];
	assign pool_dry = (free_head_q == NULL_PTR) && (fresh_q == NULL_PTR);
	assign new_cell = (free_head_q != NULL_PTR) ? free_head_q : fresh_q;

	always_comb begin
		ne_d        = ne_cur;
		head_d      = h_cur;
		tail_d      = t_cur;
		front_d     = front_q[qi_s1];
		back_d      = back_q[qi_s1];
		free_head_d = free_head_q;
		fresh_d     = fresh_q;
		wr_en       = 1'b0;
		wr_ptr_addr = t_cur;
		wr_entry    = {new_cell, val_s1};
		err_d       = spmq_pkg::ERR_OK;
		case (req_s1.operation)
			spmq_pkg::OP_PUSH: begin
				if (!q_ok_s1 || pool_dry) begin
					err_d = spmq_pkg::ERR_FULL;
				end else begin
					if (free_head_q != NULL_PTR) begin
						free_head_d = rd_ptr;
					end else begin
						fresh_d = PTR_W'(fresh_q + 1'b1);
					end
					if (ne_cur) begin
						// link the new cell after the current tail
						wr_en       = 1'b1;
						wr_ptr_addr = t_cur;
						wr_entry    = {new_cell, val_s1};
					end else begin
						head_d  = new_cell;
						front_d = val_s1;
					end
					ne_d   = 1'b1;
					tail_d = new_cell;
					back_d = val_s1;
				end
			end
			spmq_pkg::OP_POP: begin
				if (!ne_cur) begin
					err_d = spmq_pkg::ERR_EMPTY;
				end else begin
					// old head goes to the front of the free list
					wr_en       = 1'b1;
					wr_ptr_addr = h_cur;
					wr_entry    = {free_head_q, val_s1};
					free_head_d = h_cur;
					if (h_cur == t_cur) begin
						ne_d = 1'b0;
					end else begin
						head_d  = rd_ptr;
						front_d = rd_dat;
					end
				end
			end
			default: begin
				err_d = spmq_pkg::ERR_OK;
			end
		endcase
	end

	always_comb begin
		logic [63:0] fw;
		logic [63:0] bw;
		fw = 64'(front_d);
		bw = 64'(back_d);
		rsp_d.front_value = ne_d ? fw[31:0] : '0;
		rsp_d.back_value  = ne_d ? bw[31:0] : '0;
		rsp_d.is_empty    = !ne_d;
		rsp_d.error       = err_d;
	end

	assign out_blocked = rsp_valid_q && rsp_stall;
	assign exec_fire   = (state_q == ST_EXEC) && !out_blocked;

	// ------------------------------------------------------------------------
	// control state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			nonempty_q  <= '0;
			free_head_q <= NULL_PTR;
			fresh_q     <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						free_head_q <= free_head_d;
						fresh_q     <= fresh_d;
						if (q_ok_s1) begin
							nonempty_q[qi_s1] <= ne_d;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_data;
		end
		if (exec_fire) begin
			rsp_q <= rsp_d;
			if (q_ok_s1) begin
				head_q[qi_s1]  <= head_d;
				tail_q[qi_s1]  <= tail_d;
				front_q[qi_s1] <= front_d;
				back_q[qi_s1]  <= back_d;
			end
		end
	end

	// link memory, one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= link_mem[rd_ptr_addr[IDX_W-1:0]];
		end
		if (exec_fire && wr_en) begin
			link_mem[wr_ptr_addr[IDX_W-1:0]] <= wr_entry;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef ASSERT_OFF
	// an accepted request always moves into the update cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted request did not enter update cycle");

	// every finished update shows up as a response
	a_fire_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> rsp_valid)
		else $error("update finished without a response");

	// a pool full refusal on a real queue only when no cell is left
	a_full_dry: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && q_ok_s1 && (rsp_d.error == spmq_pkg::ERR_FULL))
		|-> ((free_head_q == NULL_PTR) && (fresh_q == NULL_PTR)))
		else $error("push refused while cells remain");

	// the link memory is written only during an update
	a_wr_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && exec_fire) |-> (state_q == ST_EXEC) && !accept)
		else $error("link write outside the update cycle");
`endif

endmodule
